FILE: src/button_ladder_debounce_encoder_scan_top_assert.svh
// Assertion macros for the button scan block.
// Used by button_ladder_debounce_encoder_scan_top; expects i_clk and i_rst_n in scope.
`ifndef BUTTON_LADDER_DEBOUNCE_ENCODER_SCAN_TOP_ASSERT_SVH
`define BUTTON_LADDER_DEBOUNCE_ENCODER_SCAN_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bld_pkg.sv
// Package for the button scan block: sizes, register indexes, item and status types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bld_pkg;

    // Block sizes
    localparam int unsigned DIGITAL_PINS       = 21;
    localparam int unsigned LADDERS            = 2;
    localparam int unsigned BUTTONS_PER_LADDER = 6;
    localparam int unsigned ENCODERS           = 6;
    localparam int unsigned PLAIN_BUTTONS      = 9;

    localparam int unsigned LADDER_BITS    = LADDERS * BUTTONS_PER_LADDER;
    localparam int unsigned VIRTUAL_INPUTS = DIGITAL_PINS + LADDER_BITS;
    // span of levels the encoders may address; beyond the inputs they read released
    localparam int unsigned ENC_SPAN       = PLAIN_BUTTONS + 2 * ENCODERS;
    localparam int unsigned ENC_PAD_BITS   = VIRTUAL_INPUTS + ENC_SPAN;

    // Fixed field widths
    localparam int unsigned PIN_FIELD_W  = 21;
    localparam int unsigned SAMPLE_W     = 8;
    localparam int unsigned LEVELS_W     = 33;
    localparam int unsigned TURN_W       = 6;
    localparam int unsigned CFG_DATA_W   = 8;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned LADDER_LIMITS = 6;

    // Debounce counter
    localparam int unsigned COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Heartbeat
    localparam int unsigned HB_COUNT_W      = 9;
    localparam int unsigned HEARTBEAT_LIMIT = 500;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LADDER_LIMIT_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LADDER_LIMIT_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LADDER_LIMIT_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LADDER_LIMIT_FOUR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LADDER_LIMIT_FIVE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LADDER_LIMIT_SIX   = 3'd6;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST = 8'd5;
    localparam logic [LADDER_LIMITS-1:0][CFG_DATA_W-1:0] LADDER_LIMITS_RST =
        {8'd234, 8'd191, 8'd149, 8'd106, 8'd64, 8'd21};

    // Encoder state
    typedef enum logic [1:0] {
        ENC_IDLE = 2'd0,
        ENC_CW   = 2'd1,
        ENC_CCW  = 2'd2
    } t_enc_mode;

    // Input item
    typedef struct packed {
        logic [PIN_FIELD_W-1:0] pin_levels;
        logic                   adc_fresh;
        logic [SAMPLE_W-1:0]    ladder_sample_a;
        logic [SAMPLE_W-1:0]    ladder_sample_b;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [LEVELS_W-1:0] debounced_levels;
        logic [TURN_W-1:0]   turning_clockwise;
        logic [TURN_W-1:0]   turning_counterclockwise;
        logic                heartbeat_led;
    } t_out_item;

    // Ladder thresholds handed to the decoder
    typedef struct packed {
        logic [LADDER_LIMITS-1:0][CFG_DATA_W-1:0] limits;
    } t_ladder_cfg;

    // Encoder status after one tick
    typedef struct packed {
        logic [ENCODERS-1:0] cw;
        logic [ENCODERS-1:0] ccw;
    } t_enc_status;

endpackage

FILE: src/bld_ladder_decode.sv
// Resistor-ladder decoder: maps each ADC sample to at most one active-low virtual button.
// Depends on bld_pkg.
`timescale 1ns / 1ps

module bld_ladder_decode
    import bld_pkg::*;
(
    input  t_ladder_cfg             i_cfg,
    input  logic [SAMPLE_W-1:0]     i_sample_a,
    input  logic [SAMPLE_W-1:0]     i_sample_b,
    output logic [LADDER_BITS-1:0]  o_levels
);

    logic [1:0][SAMPLE_W-1:0] w_samples;

    assign w_samples = {i_sample_b, i_sample_a};

    // First threshold the sample lies below picks the pressed button
    always_comb begin
        logic hit;
        o_levels = '1;
        for (int l = 0; l < LADDERS; l++) begin
            hit = 1'b0;
            for (int k = 0; k < BUTTONS_PER_LADDER; k++) begin
                if (!hit && (w_samples[l] < i_cfg.limits[k])) begin
                    o_levels[l * BUTTONS_PER_LADDER + k] = 1'b0;
                    hit = 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/bld_debounce.sv
// Per-input stability counters; a level is accepted once stable for the set tick count.
// Depends on bld_pkg.
`timescale 1ns / 1ps

module bld_debounce
    import bld_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [VIRTUAL_INPUTS-1:0] i_sampled,
    input  logic [CFG_DATA_W-1:0]     i_debounce_ticks,
    output logic [VIRTUAL_INPUTS-1:0] o_levels
);

    logic [VIRTUAL_INPUTS-1:0]              r_last;
    logic [VIRTUAL_INPUTS-1:0]              r_accepted;
    logic [VIRTUAL_INPUTS-1:0][COUNT_W-1:0] r_count;
    logic [VIRTUAL_INPUTS-1:0][COUNT_W-1:0] n_count;

    // Counter update and acceptance, one lane per input
    always_comb begin
        for (int v = 0; v < VIRTUAL_INPUTS; v++) begin
            if (r_last[v] == i_sampled[v]) begin
                n_count[v] = (r_count[v] == COUNT_MAX) ? r_count[v] : r_count[v] + 1'b1;
            end else begin
                n_count[v] = '0;
            end
            o_levels[v] = (n_count[v] >= i_debounce_ticks) ? i_sampled[v] : r_accepted[v];
        end
    end

    // State registers, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_accepted <= '0;
            r_count    <= '0;
        end else if (i_en) begin
            r_last     <= i_sampled;
            r_accepted <= o_levels;
            r_count    <= n_count;
        end
    end

endmodule

FILE: src/bld_encoder.sv
// Detent encoders: idle / clockwise / counterclockwise state machine per encoder.
// Depends on bld_pkg.
`timescale 1ns / 1ps

module bld_encoder
    import bld_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [VIRTUAL_INPUTS-1:0] i_levels,
    output t_enc_status               o_status
);

    // Encoder pins past the virtual inputs read released
    logic [ENC_PAD_BITS-1:0] w_pad;

    assign w_pad = {{ENC_SPAN{1'b1}}, i_levels};

    for (genvar e = 0; e < ENCODERS; e++) begin : g_enc
        t_enc_mode r_mode;
        t_enc_mode n_mode;
        logic      r_last_a;
        logic      r_last_b;
        logic      w_a;
        logic      w_b;

        assign w_a = w_pad[PLAIN_BUTTONS + 2 * e];
        assign w_b = w_pad[PLAIN_BUTTONS + 2 * e + 1];

        // State register
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mode   <= ENC_IDLE;
                r_last_a <= 1'b1;
                r_last_b <= 1'b1;
            end else if (i_en) begin
                r_mode   <= n_mode;
                r_last_a <= w_a;
                r_last_b <= w_b;
            end
        end

        // Next state
        always_comb begin
            unique case (r_mode)
                ENC_CW: begin
                    n_mode = w_a ? ENC_IDLE : ENC_CW;
                end
                ENC_CCW: begin
                    n_mode = w_b ? ENC_IDLE : ENC_CCW;
                end
                default: begin
                    if (!w_a && r_last_a && w_b) begin
                        n_mode = ENC_CW;
                    end else if (!w_b && r_last_b && w_a) begin
                        n_mode = ENC_CCW;
                    end else begin
                        n_mode = ENC_IDLE;
                    end
                end
            endcase
        end

        // Status bits
        assign o_status.cw[e]  = (n_mode == ENC_CW);
        assign o_status.ccw[e] = (n_mode == ENC_CCW);
    end

endmodule

FILE: src/button_ladder_debounce_encoder_scan_top.sv
// Top level of the button scan block: input register, config registers, heartbeat,
// result register. Depends on bld_pkg, bld_ladder_decode, bld_debounce, bld_encoder.
`timescale 1ns / 1ps
//
// Usage
//   Each input item is one scan tick: 21 raw active-low pin levels and, when
//   adc_fresh is set, one new sample per resistor ladder. Each tick gives exactly
//   one result item: 33 debounced levels, clockwise and counterclockwise flags
//   for six encoders and the heartbeat LED level.
//   Both channels are valid/ready. An item accepted into the input register is
//   processed from there and its result is captured in the result register.
//   One item per cycle is sustained while the receiver does not stall; the rate
//   is set by the single processing stage between input and result register.
//   When the receiver stalls, the result register holds its item and the input
//   register holds the next one; a third item is refused until the result drains.
//   The configuration port writes a register at any edge with i_cfg_we high;
//   index 0 is the debounce tick count, indexes 1 to 6 the ladder thresholds,
//   higher indexes are ignored. Write it only while the block is idle.
//   Synchronous reset restores the register defaults, clears all counters,
//   levels and encoder states and empties both pipeline registers.
//
module button_ladder_debounce_encoder_scan_top
    import bld_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_item,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic                      r_in_valid;
    t_in_item                  r_in;
    logic                      r_out_valid;
    t_out_item                 r_out;
    logic                      w_adv;

    logic [CFG_DATA_W-1:0]     r_debounce_ticks;
    t_ladder_cfg               r_ladder_cfg;

    logic [LADDER_BITS-1:0]    r_ladder_levels;
    logic [LADDER_BITS-1:0]    n_ladder_levels;
    logic [LADDER_BITS-1:0]    w_decoded;
    logic [VIRTUAL_INPUTS-1:0] w_sampled;
    logic [VIRTUAL_INPUTS-1:0] w_levels;
    t_enc_status               w_enc;

    logic [HB_COUNT_W-1:0]     r_hb_count;
    logic [HB_COUNT_W-1:0]     n_hb_count;
    logic                      r_hb_level;
    logic                      n_hb_level;

    // Handshake: process when the result register is free or being emptied
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks    <= DEBOUNCE_TICKS_RST;
            r_ladder_cfg.limits <= LADDER_LIMITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_TICKS:     r_debounce_ticks       <= i_cfg_data;
                CFG_LADDER_LIMIT_ONE:   r_ladder_cfg.limits[0] <= i_cfg_data;
                CFG_LADDER_LIMIT_TWO:   r_ladder_cfg.limits[1] <= i_cfg_data;
                CFG_LADDER_LIMIT_THREE: r_ladder_cfg.limits[2] <= i_cfg_data;
                CFG_LADDER_LIMIT_FOUR:  r_ladder_cfg.limits[3] <= i_cfg_data;
                CFG_LADDER_LIMIT_FIVE:  r_ladder_cfg.limits[4] <= i_cfg_data;
                CFG_LADDER_LIMIT_SIX:   r_ladder_cfg.limits[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ladder decode; ladder levels hold between fresh samples
    bld_ladder_decode u_ladder (
        .i_cfg      (r_ladder_cfg),
        .i_sample_a (r_in.ladder_sample_a),
        .i_sample_b (r_in.ladder_sample_b),
        .o_levels   (w_decoded)
    );

    assign n_ladder_levels = r_in.adc_fresh ? w_decoded : r_ladder_levels;
    assign w_sampled       = {n_ladder_levels, r_in.pin_levels[DIGITAL_PINS-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ladder_levels <= '0;
        end else if (w_adv) begin
            r_ladder_levels <= n_ladder_levels;
        end
    end

    // Debounce
    bld_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_adv),
        .i_sampled        (w_sampled),
        .i_debounce_ticks (r_debounce_ticks),
        .o_levels         (w_levels)
    );

    // Encoders
    bld_encoder u_encoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_levels (w_levels),
        .o_status (w_enc)
    );

    // Heartbeat: toggle on the tick that finds the count past the limit
    always_comb begin
        if (r_hb_count > HB_COUNT_W'(HEARTBEAT_LIMIT)) begin
            n_hb_count = '0;
            n_hb_level = !r_hb_level;
        end else begin
            n_hb_count = r_hb_count + 1'b1;
            n_hb_level = r_hb_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_count <= '0;
            r_hb_level <= 1'b0;
        end else if (w_adv) begin
            r_hb_count <= n_hb_count;
            r_hb_level <= n_hb_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.debounced_levels         <= LEVELS_W'(w_levels);
            r_out.turning_clockwise        <= TURN_W'(w_enc.cw);
            r_out.turning_counterclockwise <= TURN_W'(w_enc.ccw);
            r_out.heartbeat_led            <= n_hb_level;
        end
    end

    // Checks
`include "button_ladder_debounce_encoder_scan_top_assert.svh"

    `BLD_ASSERT_SAME(a_enc_exclusive, o_out_valid,
        (o_out_item.turning_clockwise & o_out_item.turning_counterclockwise) == '0,
        "encoder flagged clockwise and counterclockwise at once")
    `BLD_ASSERT_SAME(a_hb_range, 1'b1, r_hb_count <= HB_COUNT_W'(HEARTBEAT_LIMIT + 1),
        "heartbeat count past its wrap point")
    `BLD_ASSERT_NEXT(a_in_hold, r_in_valid && !w_adv, r_in_valid,
        "stalled input item dropped")
    `BLD_ASSERT_NEXT(a_ladder_one_hot, w_adv && r_in.adc_fresh,
        $countones(~r_ladder_levels[BUTTONS_PER_LADDER-1:0]) <= 1,
        "more than one ladder button pressed after a fresh sample")

endmodule
